@@ design/actr_pkg.sv @@
// Shared types and constants for the AES-128 CTR stream cipher.
`default_nettype none
package actr_pkg;

  // Byte 0 of a block sits in the most significant bits.
  typedef logic [0:15][7:0] blk_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] tag;    // counter value of the block in flight
    logic [3:0]  epoch;  // packet/config generation at launch
  } cell_ctl_t;

  localparam int unsigned IV_BYTES  = 8;
  localparam int unsigned NUM_RNDS  = 10;
  // One input stage plus one cell per round.
  localparam int unsigned CHAIN_LAT = NUM_RNDS + 1;

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage
`default_nettype wire

@@ design/actr_in_if.sv @@
// Input byte channel.
`default_nettype none
interface actr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ design/actr_out_if.sv @@
// Result byte channel.
`default_nettype none
interface actr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

@@ design/aes128_ctr_stream_cipher.sv @@
// Top level: AES-128 CTR (RFC 3686 layout) byte-stream cipher.
`default_nettype none
// Packets come in one word (byte) per cycle unless ready is low; the first 8
// bytes are the IV and pass through unchanged, later bytes are XORed with
// keystream. Keystream blocks come from a chain of ten round cells behind an
// input whitening stage, one block in flight at a time, so a new block can
// start only once the last one has landed. Sustained rate is 1 word per cycle
// while the output drains. The first payload word of a packet waits after the
// last IV word while the first block runs through the chain; each later block
// is computed while the 16 words of the current one go out, so it adds no gap.
// Input is taken only while the output register is empty or being drained.
// Config: APB, 64-bit data, key_high at 0x00, key_low at 0x08, salt_nonce at
// 0x10. A write drops any precomputed next block; the block in use is kept.
module aes128_ctr_stream_cipher (
  input  wire          clk,
  input  wire          rst_n,
  actr_in_if.sink      in_word,
  actr_out_if.source   out_word,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [4:0]   cfg_paddr,
  input  wire  [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import actr_pkg::*;

  localparam logic [1:0] REG_KEY_HI = 2'd0;
  localparam logic [1:0] REG_KEY_LO = 2'd1;
  localparam logic [1:0] REG_NONCE  = 2'd2;

  // config registers
  logic [63:0] key_hi_r, key_lo_r;
  logic [31:0] nonce_r;
  logic        cfg_wr;

  // stream state
  logic [63:0] iv_r, iv_nxt;
  logic [3:0]  ivc_r, ivc_nxt;
  logic [15:0] ctr_r, ctr_nxt;
  logic [3:0]  bib_r, bib_nxt;
  logic [3:0]  ep_r, ep_nxt;
  blk_t        cur_r, cur_nxt, nxt_r, nxt_nxt;
  logic        cur_v_r, cur_v_nxt, nxt_v_r, nxt_v_nxt;
  logic [3:0]  fly_r;

  // output register
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        iv_done, acc, pay, wrap, quiet, lch_cur, lch_nxt, launch, res_ok;
  logic [15:0] lch_tag;
  logic [7:0]  o_byte;

  // cell chain
  blk_t      st [0:NUM_RNDS];
  blk_t      kk [0:NUM_RNDS];
  cell_ctl_t ct [0:NUM_RNDS];
  blk_t      s0_st_r, s0_key_r, key_full, cblk;
  cell_ctl_t s0_ctl_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_KEY_HI: cfg_prdata = key_hi_r;
      REG_KEY_LO: cfg_prdata = key_lo_r;
      REG_NONCE:  cfg_prdata = {32'h0, nonce_r};
      default:    cfg_prdata = 64'h0;
    endcase
  end

  assign iv_done       = (ivc_r == 4'(IV_BYTES));
  assign in_word.ready = (!out_vld_r || out_word.ready) && (!iv_done || cur_v_r);
  assign acc           = in_word.valid && in_word.ready;
  assign pay           = acc && iv_done;
  assign wrap          = pay && (bib_r == 4'hf);

  // launch a block only in cycles where nothing moves the window or epoch
  assign quiet   = !cfg_wr && !(acc && in_word.last_byte) && !wrap;
  assign lch_cur = quiet && iv_done && (fly_r == 4'd0) && !cur_v_r;
  assign lch_nxt = quiet && iv_done && (fly_r == 4'd0) && cur_v_r && !nxt_v_r;
  assign launch  = lch_cur || lch_nxt;
  assign lch_tag = lch_cur ? ctr_r : ctr_r + 16'd1;

  assign key_full = {key_hi_r, key_lo_r};
  assign cblk     = {nonce_r, iv_r, 16'h0, lch_tag};

  always_comb begin
    iv_nxt    = iv_r;
    ivc_nxt   = ivc_r;
    ctr_nxt   = ctr_r;
    bib_nxt   = bib_r;
    ep_nxt    = ep_r;
    cur_nxt   = cur_r;
    nxt_nxt   = nxt_r;
    cur_v_nxt = cur_v_r;
    nxt_v_nxt = nxt_v_r;
    o_byte    = in_word.data_byte;
    if (acc) begin
      if (!iv_done) begin
        iv_nxt  = {iv_r[55:0], in_word.data_byte};
        ivc_nxt = ivc_r + 4'd1;
      end else begin
        o_byte  = in_word.data_byte ^ cur_r[bib_r];
        bib_nxt = bib_r + 4'd1;
        if (wrap) begin
          // block used up: next one slides in
          ctr_nxt   = ctr_r + 16'd1;
          cur_nxt   = nxt_r;
          cur_v_nxt = nxt_v_r;
          nxt_v_nxt = 1'b0;
        end
      end
      if (in_word.last_byte) begin
        ivc_nxt   = 4'd0;
        ctr_nxt   = 16'd1;
        bib_nxt   = 4'd0;
        cur_v_nxt = 1'b0;
        nxt_v_nxt = 1'b0;
      end
    end
    if (cfg_wr) begin
      nxt_v_nxt = 1'b0;   // key or nonce changed: recompute ahead blocks
    end
    if (cfg_wr || (acc && in_word.last_byte)) begin
      ep_nxt = ep_r + 4'd1;
    end
    // chain result lands where its counter tag says, if still current
    res_ok = ct[NUM_RNDS].vld && (ct[NUM_RNDS].epoch == ep_r) && (ep_nxt == ep_r);
    if (res_ok) begin
      if (!cur_v_nxt && ct[NUM_RNDS].tag == ctr_nxt) begin
        cur_nxt   = st[NUM_RNDS];
        cur_v_nxt = 1'b1;
      end else if (cur_v_nxt && !nxt_v_nxt && ct[NUM_RNDS].tag == ctr_nxt + 16'd1) begin
        nxt_nxt   = st[NUM_RNDS];
        nxt_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r   <= 64'h0;
      key_lo_r   <= 64'h0;
      nonce_r    <= 32'h0;
      iv_r       <= 64'h0;
      ivc_r      <= 4'd0;
      ctr_r      <= 16'd1;
      bib_r      <= 4'd0;
      ep_r       <= 4'd0;
      cur_v_r    <= 1'b0;
      nxt_v_r    <= 1'b0;
      fly_r      <= 4'd0;
      out_vld_r  <= 1'b0;
      s0_ctl_r.vld <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[4:3])
          REG_KEY_HI: key_hi_r <= cfg_pwdata;
          REG_KEY_LO: key_lo_r <= cfg_pwdata;
          REG_NONCE:  nonce_r  <= cfg_pwdata[31:0];
          default:    ;
        endcase
      end
      iv_r    <= iv_nxt;
      ivc_r   <= ivc_nxt;
      ctr_r   <= ctr_nxt;
      bib_r   <= bib_nxt;
      ep_r    <= ep_nxt;
      cur_v_r <= cur_v_nxt;
      nxt_v_r <= nxt_v_nxt;
      // count past the chain's depth so the landed result is seen before relaunch
      if (launch) begin
        fly_r <= 4'(CHAIN_LAT + 1);
      end else if (fly_r != 4'd0) begin
        fly_r <= fly_r - 4'd1;
      end
      if (acc) begin
        out_vld_r <= 1'b1;
      end else if (out_word.ready) begin
        out_vld_r <= 1'b0;
      end
      s0_ctl_r.vld <= launch;
    end
    cur_r <= cur_nxt;
    nxt_r <= nxt_nxt;
    if (acc) begin
      out_byte_r <= o_byte;
      out_last_r <= in_word.last_byte;
    end
    s0_st_r        <= cblk ^ key_full;
    s0_key_r       <= key_full;
    s0_ctl_r.tag   <= lch_tag;
    s0_ctl_r.epoch <= ep_r;
  end

  assign st[0] = s0_st_r;
  assign kk[0] = s0_key_r;
  assign ct[0] = s0_ctl_r;

  for (genvar r = 1; r <= NUM_RNDS; r++) begin : g_cell
    actr_round_cell #(.ROUND(r)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .st_i  (st[r-1]),
      .key_i (kk[r-1]),
      .ctl_i (ct[r-1]),
      .st_o  (st[r]),
      .ctl_o (ct[r]),
      .key_o (kk[r])
    );
  end

  assign out_word.valid    = out_vld_r;
  assign out_word.out_byte = out_byte_r;
  assign out_word.out_last = out_last_r;

  // a payload word is only taken against a live keystream block
  a_pay_has_ks: assert property (@(posedge clk) disable iff (!rst_n)
    pay |-> cur_v_r) else $error("payload accepted without keystream");

  // a lookahead block never exists without the current one
  a_nxt_needs_cur: assert property (@(posedge clk) disable iff (!rst_n)
    nxt_v_r |-> cur_v_r) else $error("next block valid without current");

  // keystream only exists once the IV is complete
  a_cur_after_iv: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> iv_done) else $error("keystream valid during IV");

  // chain holds one block at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> (fly_r == 4'd0)) else $error("launch while chain busy");
endmodule
`default_nettype wire

@@ design/actr_round_cell.sv @@
// One AES-128 round plus its key-schedule step, registered.
`default_nettype none
module actr_round_cell #(
  parameter int unsigned ROUND = 1
) (
  input  wire                clk,
  input  wire                rst_n,
  input  actr_pkg::blk_t      st_i,
  input  actr_pkg::blk_t      key_i,
  input  actr_pkg::cell_ctl_t ctl_i,
  output actr_pkg::blk_t      st_o,
  output actr_pkg::cell_ctl_t ctl_o,
  output actr_pkg::blk_t      key_o
);
  import actr_pkg::*;

  localparam logic [7:0] RC   = RCON[ROUND-1];
  localparam bit         LAST = (ROUND == NUM_RNDS);

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  blk_t st_r, key_r;
  cell_ctl_t ctl_r;
  blk_t sub, shf, mix, rk, st_nxt;
  logic [7:0] a0, a1, a2, a3, all;

  always_comb begin
    // key schedule: next round key from the previous one
    rk[0] = key_i[0] ^ SBOX[key_i[13]] ^ RC;
    rk[1] = key_i[1] ^ SBOX[key_i[14]];
    rk[2] = key_i[2] ^ SBOX[key_i[15]];
    rk[3] = key_i[3] ^ SBOX[key_i[12]];
    for (int i = 4; i < 16; i++) begin
      rk[i] = key_i[i] ^ rk[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      sub[i] = SBOX[st_i[i]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        shf[j + 4*c] = sub[j + 4*((c + j) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = shf[4*c];
      a1  = shf[4*c+1];
      a2  = shf[4*c+2];
      a3  = shf[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      mix[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
      mix[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
      mix[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
      mix[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    st_nxt = (LAST ? shf : mix) ^ rk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_i.vld;
    end
    ctl_r.tag   <= ctl_i.tag;
    ctl_r.epoch <= ctl_i.epoch;
    st_r        <= st_nxt;
    key_r       <= rk;
  end

  assign st_o  = st_r;
  assign key_o = key_r;
  assign ctl_o = ctl_r;
endmodule
`default_nettype wire
